@@ hw/rtl/lagrange_table_interpolator_assert.svh @@
// Assertion macros shared by the interpolator modules.
`ifndef LAGRANGE_TABLE_INTERPOLATOR_ASSERT_SVH
`define LAGRANGE_TABLE_INTERPOLATOR_ASSERT_SVH

// Same-cycle implication, checked on every clock outside reset.
`define LTI_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lagrange_table_interpolator: check failed");

// Next-cycle implication, checked on every clock outside reset.
`define LTI_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lagrange_table_interpolator: check failed");

`endif

@@ hw/rtl/lti_pkg.sv @@
package lti_pkg;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_EQUAL = 2'd2;

  localparam int unsigned FRAC_BITS = 30;
  localparam logic [31:0] MAG_MAX   = 32'hFFFF_FFFF;
  localparam logic [31:0] ONE_Q30   = 32'h4000_0000;
  localparam logic [63:0] HALF_Q30  = 64'h0000_0000_2000_0000;

  typedef struct packed {
    logic               is_query;
    logic               load_ok;
    logic [9:0]         entry_index;
    logic signed [47:0] time_value;
    logic signed [31:0] plus_value;
    logic signed [31:0] cross_value;
    logic               component;
  } q_item_t;

endpackage

@@ hw/rtl/lti_front.sv @@
module lti_front #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  action,
  input  logic [9:0]            entry_index,
  input  logic signed [47:0]    time_value,
  input  logic signed [31:0]    plus_value,
  input  logic signed [31:0]    cross_value,
  input  logic                  component,
  output logic                  q_valid,
  output lti_pkg::q_item_t      q_item,
  input  logic                  q_pop
);

  lti_pkg::q_item_t slot [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;
  lti_pkg::q_item_t in_item;

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slot[rd_ptr];

  always_comb begin
    in_item.is_query    = (action == lti_pkg::ACT_QUERY);
    in_item.load_ok     = (32'(entry_index) < TABLE_DEPTH);
    in_item.entry_index = entry_index;
    in_item.time_value  = time_value;
    in_item.plus_value  = plus_value;
    in_item.cross_value = cross_value;
    in_item.component   = component;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

`include "lagrange_table_interpolator_assert.svh"

  `LTI_ASSERT_IMP(a_pop_nonempty, q_pop, count != 2'd0)
  `LTI_ASSERT_NXT(a_full_holds, count == 2'd2 && !q_pop, count == 2'd2)

endmodule

@@ hw/rtl/lti_back.sv @@
module lti_back #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [10:0]           sample_count,
  input  logic                  q_valid,
  input  lti_pkg::q_item_t      q_item,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [31:0]    interpolated,
  output logic [1:0]            status
);

  localparam int unsigned IW = $clog2(TABLE_DEPTH);

  typedef enum logic [21:0] {
    S_IDLE     = 22'h000001,
    S_R0       = 22'h000002,
    S_R0_CMP   = 22'h000004,
    S_RL       = 22'h000008,
    S_RL_CMP   = 22'h000010,
    S_DN       = 22'h000020,
    S_DN_CMP   = 22'h000040,
    S_UP       = 22'h000080,
    S_UP_CMP   = 22'h000100,
    S_WSET     = 22'h000200,
    S_WIN_RD   = 22'h000400,
    S_WIN_CAP  = 22'h000800,
    S_EQ       = 22'h001000,
    S_FACT     = 22'h002000,
    S_DIV_CHK  = 22'h004000,
    S_DIV      = 22'h008000,
    S_MUL      = 22'h010000,
    S_MUL_UPD  = 22'h020000,
    S_TERM     = 22'h040000,
    S_TERM_ACC = 22'h080000,
    S_FIN      = 22'h100000,
    S_DONE     = 22'h200000
  } state_t;

  localparam logic signed [37:0] ACC_MAX = 38'sh00_7FFF_FFFF;
  localparam logic signed [37:0] ACC_MIN = -38'sh00_8000_0000;

  state_t state;

  logic signed [47:0] time_mem  [TABLE_DEPTH];
  logic signed [31:0] plus_mem  [TABLE_DEPTH];
  logic signed [31:0] cross_mem [TABLE_DEPTH];
  logic signed [47:0] time_rd;
  logic signed [31:0] plus_rd;
  logic signed [31:0] cross_rd;
  logic [IW-1:0]      raddr;
  logic               mem_we;
  logic [IW-1:0]      waddr;

  logic [10:0]        sc_reg;
  logic [31:0]        used_n;
  logic [IW-1:0]      last_idx;
  logic [IW-1:0]      top_idx;
  logic [IW-1:0]      cursor;
  logic [IW-1:0]      cur;
  logic [IW-1:0]      kmin;
  logic [IW:0]        cur_plus2;
  logic [IW:0]        kmax;

  logic signed [47:0] t_q;
  logic               comp;
  logic signed [47:0] win_t [4];
  logic signed [31:0] win_v [4];
  logic [1:0]         widx;
  logic [1:0]         m_last;
  logic [1:0]         kk;
  logic [1:0]         jj;
  logic [2:0]         j_step;
  logic [2:0]         j_next;
  logic               eq_hit;

  logic signed [48:0] num_d;
  logic signed [48:0] den_d;
  logic [48:0]        num_mag;
  logic [48:0]        den_mag;
  logic               fneg;
  logic [48:0]        rem;
  logic [49:0]        rem_sh;
  logic [31:0]        dvd_lo;
  logic [31:0]        quo;
  logic [4:0]         bitcnt;
  logic [31:0]        pmag;
  logic               pneg;
  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic [63:0]        mul_p;
  logic [31:0]        vmag;
  logic               vneg;
  logic [63:0]        term_rnd;
  logic [33:0]        term;
  logic [33:0]        prod_hi;
  logic signed [37:0] acc;
  logic signed [31:0] res_val;
  logic [1:0]         res_st;
  logic               out_free;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign q_pop     = (state == S_IDLE) && q_valid;
  assign mem_we    = q_pop && !q_item.is_query && q_item.load_ok;
  assign waddr     = IW'(q_item.entry_index);

  always_comb begin
    if (32'(sc_reg) < 32'd2) begin
      used_n = 32'd2;
    end else if (32'(sc_reg) > TABLE_DEPTH) begin
      used_n = TABLE_DEPTH;
    end else begin
      used_n = 32'(sc_reg);
    end
    last_idx = IW'(used_n - 32'd2);
    top_idx  = IW'(used_n - 32'd1);
  end

  always_comb begin
    kmin      = (cur == '0) ? '0 : cur - IW'(1);
    cur_plus2 = {1'b0, cur} + (IW+1)'(2);
    kmax      = (cur_plus2 > {1'b0, top_idx}) ? {1'b0, top_idx} : cur_plus2;
  end

  always_comb begin
    unique case (state)
      S_RL:    raddr = last_idx;
      S_DN:    raddr = cur;
      S_UP:    raddr = cur + IW'(1);
      S_WIN_RD: raddr = kmin + IW'(widx);
      default: raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      time_mem[waddr]  <= q_item.time_value;
      plus_mem[waddr]  <= q_item.plus_value;
      cross_mem[waddr] <= q_item.cross_value;
    end
    time_rd  <= time_mem[raddr];
    plus_rd  <= plus_mem[raddr];
    cross_rd <= cross_mem[raddr];
  end

  always_comb begin
    eq_hit = 1'b0;
    for (int a = 0; a < 4; a++) begin
      for (int b = a + 1; b < 4; b++) begin
        if (2'(b) <= m_last && win_t[a] == win_t[b]) begin
          eq_hit = 1'b1;
        end
      end
    end
  end

  always_comb begin
    num_d  = {t_q[47], t_q} - {win_t[jj][47], win_t[jj]};
    den_d  = {win_t[kk][47], win_t[kk]} - {win_t[jj][47], win_t[jj]};
    rem_sh = {rem, dvd_lo[31]};
    j_step = {1'b0, jj} + 3'd1;
    j_next = (j_step == {1'b0, kk}) ? j_step + 3'd1 : j_step;
    vneg   = win_v[kk][31];
    vmag   = vneg ? 32'(-win_v[kk]) : 32'(win_v[kk]);
    mul_a  = (state == S_TERM) ? vmag : pmag;
    mul_b  = (state == S_TERM) ? pmag : quo;
    prod_hi  = mul_p[63:30];
    term_rnd = mul_p + lti_pkg::HALF_Q30;
    term     = term_rnd[63:30];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      cursor    <= '0;
      sc_reg    <= 11'd2;
    end else begin
      if (cfg_valid && cfg_ready) begin
        sc_reg <= sample_count;
        cursor <= '0;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid && q_item.is_query) begin
            t_q   <= q_item.time_value;
            comp  <= q_item.component;
            state <= S_R0;
          end
        end
        S_R0: begin
          state <= S_R0_CMP;
        end
        S_R0_CMP: begin
          if (t_q < time_rd) begin
            res_val <= '0;
            res_st  <= lti_pkg::ST_RANGE;
            state   <= S_DONE;
          end else begin
            state <= S_RL;
          end
        end
        S_RL: begin
          state <= S_RL_CMP;
        end
        S_RL_CMP: begin
          if (t_q > time_rd) begin
            res_val <= '0;
            res_st  <= lti_pkg::ST_RANGE;
            state   <= S_DONE;
          end else begin
            cur   <= (cursor > last_idx) ? last_idx : cursor;
            state <= S_DN;
          end
        end
        S_DN: begin
          state <= (cur == '0) ? S_UP : S_DN_CMP;
        end
        S_DN_CMP: begin
          if (t_q < time_rd) begin
            cur   <= cur - IW'(1);
            state <= S_DN;
          end else begin
            state <= S_UP;
          end
        end
        S_UP: begin
          state <= (cur == last_idx) ? S_WSET : S_UP_CMP;
        end
        S_UP_CMP: begin
          if (t_q >= time_rd) begin
            cur   <= cur + IW'(1);
            state <= S_UP;
          end else begin
            state <= S_WSET;
          end
        end
        S_WSET: begin
          cursor <= cur;
          m_last <= 2'(kmax - {1'b0, kmin});
          widx   <= 2'd0;
          state  <= S_WIN_RD;
        end
        S_WIN_RD: begin
          state <= S_WIN_CAP;
        end
        S_WIN_CAP: begin
          win_t[widx] <= time_rd;
          win_v[widx] <= comp ? cross_rd : plus_rd;
          if (widx == m_last) begin
            state <= S_EQ;
          end else begin
            widx  <= widx + 2'd1;
            state <= S_WIN_RD;
          end
        end
        S_EQ: begin
          if (eq_hit) begin
            res_val <= '0;
            res_st  <= lti_pkg::ST_EQUAL;
            state   <= S_DONE;
          end else begin
            kk    <= 2'd0;
            jj    <= 2'd1;
            pmag  <= lti_pkg::ONE_Q30;
            pneg  <= 1'b0;
            acc   <= '0;
            state <= S_FACT;
          end
        end
        S_FACT: begin
          num_mag <= num_d[48] ? 49'(-num_d) : 49'(num_d);
          den_mag <= den_d[48] ? 49'(-den_d) : 49'(den_d);
          fneg    <= (num_d[48] != den_d[48]) && (num_d != '0);
          state   <= S_DIV_CHK;
        end
        S_DIV_CHK: begin
          if ({2'b00, num_mag} >= {den_mag, 2'b00}) begin
            quo   <= lti_pkg::MAG_MAX;
            state <= S_MUL;
          end else begin
            rem    <= {2'b00, num_mag[48:2]};
            dvd_lo <= {num_mag[1:0], 30'd0};
            quo    <= '0;
            bitcnt <= '0;
            state  <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem_sh >= {1'b0, den_mag}) begin
            rem <= 49'(rem_sh - {1'b0, den_mag});
            quo <= {quo[30:0], 1'b1};
          end else begin
            rem <= rem_sh[48:0];
            quo <= {quo[30:0], 1'b0};
          end
          dvd_lo <= {dvd_lo[30:0], 1'b0};
          bitcnt <= bitcnt + 5'd1;
          if (bitcnt == 5'd31) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          mul_p <= mul_a * mul_b;
          state <= S_MUL_UPD;
        end
        S_MUL_UPD: begin
          pmag <= (prod_hi[33:32] != 2'b00) ? lti_pkg::MAG_MAX : prod_hi[31:0];
          pneg <= pneg ^ fneg;
          jj   <= j_next[1:0];
          state <= (j_next > {1'b0, m_last}) ? S_TERM : S_FACT;
        end
        S_TERM: begin
          mul_p <= mul_a * mul_b;
          state <= S_TERM_ACC;
        end
        S_TERM_ACC: begin
          if (vneg != pneg) begin
            acc <= acc - 38'(term);
          end else begin
            acc <= acc + 38'(term);
          end
          if (kk == m_last) begin
            state <= S_FIN;
          end else begin
            kk    <= kk + 2'd1;
            jj    <= 2'd0;
            pmag  <= lti_pkg::ONE_Q30;
            pneg  <= 1'b0;
            state <= S_FACT;
          end
        end
        S_FIN: begin
          if (acc > ACC_MAX) begin
            res_val <= 32'sh7FFF_FFFF;
          end else if (acc < ACC_MIN) begin
            res_val <= -32'sh8000_0000;
          end else begin
            res_val <= acc[31:0];
          end
          res_st <= lti_pkg::ST_OK;
          state  <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            interpolated <= res_val;
            status       <= res_st;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`include "lagrange_table_interpolator_assert.svh"

  `LTI_ASSERT_IMP(a_cursor_bound, 1'b1, cursor <= last_idx)
  `LTI_ASSERT_IMP(a_range_zero, out_valid && status == lti_pkg::ST_RANGE, interpolated == '0)
  `LTI_ASSERT_NXT(a_eq_done, state == S_EQ && eq_hit, state == S_DONE && res_st == lti_pkg::ST_EQUAL)
  `LTI_ASSERT_IMP(a_pop_idle, q_pop, state == S_IDLE)

endmodule

@@ hw/rtl/lagrange_table_interpolator.sv @@
// Loads are written to the table as they leave the 2-entry input queue; no result.
// Queries: range check, cursor search down then up, window set, window capture point
// by point, equal check, then each Lagrange factor (divider skipped on saturation)
// on one shared 32-step divider and 32x32 multiplier (up to 12 factors), a product per
// term and a final clamp. One query in flight at a time.
// Synchronous reset empties the queue and output, sets sample_count to 2 and cursor to 0.
module lagrange_table_interpolator #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [10:0]        sample_count,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               action,
  input  logic [9:0]         entry_index,
  input  logic signed [47:0] time_value,
  input  logic signed [31:0] plus_value,
  input  logic signed [31:0] cross_value,
  input  logic               component,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] interpolated,
  output logic [1:0]         status
);

  logic             q_valid;
  logic             q_pop;
  lti_pkg::q_item_t q_item;

  lti_front #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .entry_index (entry_index),
    .time_value  (time_value),
    .plus_value  (plus_value),
    .cross_value (cross_value),
    .component   (component),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop)
  );

  lti_back #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .sample_count (sample_count),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .interpolated (interpolated),
    .status       (status)
  );

endmodule
